@@ rtl/spline_keyframe_pose_interpolator_defines.svh @@
// assertion macros for the keyframe pose interpolator
// expects clk_i and rst_ni in the scope of use
`ifndef SPLINE_KEYFRAME_POSE_INTERPOLATOR_DEFINES_SVH
`define SPLINE_KEYFRAME_POSE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define SKPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skpi assertion failed");

// next-cycle implication
`define SKPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skpi assertion failed");

`endif

@@ rtl/skpi_pkg.sv @@
// shared types, constants and arithmetic helpers of the keyframe pose interpolator
// no dependencies
package skpi_pkg;

  localparam int MaxKeys    = 8;
  localparam int NumCh      = 7;
  localparam int FracBits   = 16;
  localparam int WgtBits    = 28;
  localparam int KeyW       = $clog2(MaxKeys);
  localparam int StoreDepth = MaxKeys * NumCh;
  localparam int AddrW      = $clog2(StoreDepth);

  localparam logic [63:0] NormOne = 64'd1 << (2 * FracBits);
  localparam logic [63:0] NormTol = (NormOne + 64'd50) / 64'd100;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } skpi_req_e;

  typedef enum logic [1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_SPLINE_MODE = 2'd1,
    CFG_KEY_COUNT   = 2'd2
  } skpi_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_U3, ST_W_START, ST_W_RUN, ST_W_DONE,
    ST_A_RD, ST_A_MUL, ST_A_ADD, ST_N_MUL, ST_N_ADD, ST_N_CHK,
    ST_S_RUN, ST_N_START, ST_N_RUN, ST_N_DONE, ST_M_MUL, ST_FIN
  } skpi_state_e;

  typedef struct packed {
    skpi_req_e          req_type;
    logic [2:0]         key_slot;
    logic [2:0]         channel_sel;
    logic signed [31:0] key_value;
  } skpi_req_t;

  typedef struct packed {
    logic signed [31:0] rot_0_0;
    logic signed [31:0] rot_1_0;
    logic signed [31:0] rot_2_0;
    logic signed [31:0] rot_0_1;
    logic signed [31:0] rot_1_1;
    logic signed [31:0] rot_2_1;
    logic signed [31:0] rot_0_2;
    logic signed [31:0] rot_1_2;
    logic signed [31:0] rot_2_2;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } skpi_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // shift right rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                 input int unsigned sh);
    logic [63:0] mag;
    mag = x[63] ? (64'd0 - x) : x;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] twice_sum(input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
    return sat32(rnd_shr(sat_add64(p1, p2), 2 * FracBits - 1));
  endfunction

  function automatic logic signed [31:0] one_minus(input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
    logic signed [63:0] v;
    v = rnd_shr(sat_add64(p1, p2), 2 * FracBits - 1);
    return sat32((64'sd1 <<< FracBits) - v);
  endfunction

endpackage

@@ rtl/skpi_ram.sv @@
// generic simple dual-port ram, registered read
// no dependencies
module skpi_ram #(
  parameter int Width = 32,
  parameter int Depth = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/spline_keyframe_pose_interpolator.sv @@
// keyframe pose interpolator top level: key store, spline, renormalize, matrix
// depends on skpi_pkg, skpi_ram and the defines header
// load request: writes the key store, no result; tick request: one result, renormalized when needed
// a new request is taken only in idle, after the last tick's result; a tick does 28 key reads over one ram port,
//   and when renormalizing the 32-step square root and the 64-step divider for the 4 renormalize divides
// reset: phase and segment zero, control and config registers to defaults, key store undefined until written
`include "spline_keyframe_pose_interpolator_defines.svh"

module spline_keyframe_pose_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  skpi_pkg::skpi_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output skpi_pkg::skpi_res_t out_res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import skpi_pkg::*;

  skpi_state_e state_q, state_d;

  logic [15:0]     phase_step_q;
  logic            spline_mode_q;
  logic [3:0]      key_count_q;
  logic [15:0]     phase_q;
  logic [KeyW-1:0] segment_q;
  logic            out_valid_q;
  logic [1:0]      widx_q;
  logic [2:0]      ch_q;
  logic [3:0]      mat_idx_q;
  logic [5:0]      div_cnt_q;

  logic [31:0]        u2_q;
  logic [47:0]        u3_q;
  logic signed [31:0] w_q [4];
  logic [KeyW-1:0]    key_q, base_key_q;
  logic signed [63:0] prod_q, acc_q;
  logic signed [31:0] q_q [NumCh];
  logic [63:0]        norm_q;
  logic [63:0]        sq_res_q, sq_rem_q, sq_bit_q;
  logic [63:0]        div_num_q;
  logic [33:0]        div_rem_q;
  logic [32:0]        div_den_q;
  logic               div_neg_q;
  logic signed [63:0] mat_q [9];
  skpi_res_t          out_res_q;

  logic             in_acc, is_tick, out_free, renorm;
  logic [KeyW:0]    cnt_eff;
  logic [KeyW-1:0]  key_next;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_rdata;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] wn;
  logic [63:0]        wn_num;
  logic [33:0]        div_sh;
  logic               div_ge;
  logic [63:0]        norm_sum, norm_diff, sq_trial;
  logic [64:0]        norm_wide;
  logic signed [63:0] acc_new, quot_s;
  logic [2:0]         opa, opb;
  logic [63:0]        nq_mag;
  logic signed [31:0] nq_x;
  skpi_res_t          res_d;
  logic [16:0]        phase_sum;

  function automatic logic [KeyW-1:0] seg_mod(input logic [KeyW-1:0] seg,
                                              input logic [KeyW:0] cnt);
    logic [KeyW:0] r;
    r = {1'b0, seg};
    for (int i = 0; i < MaxKeys; i++) begin
      if (r >= cnt) r = r - cnt;
    end
    return r[KeyW-1:0];
  endfunction

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_tick  = in_req_i.req_type == REQ_TICK;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_eff  = (key_count_q == 4'd0) ? (KeyW+1)'(1) :
                    ((KeyW+1)'(key_count_q) > (KeyW+1)'(MaxKeys)) ? (KeyW+1)'(MaxKeys) :
                    (KeyW+1)'(key_count_q);
  assign key_next = (({1'b0, key_q} + (KeyW+1)'(1)) == cnt_eff) ? '0 : key_q + 1'b1;

  assign ram_waddr = AddrW'(in_req_i.key_slot) * AddrW'(NumCh) + AddrW'(in_req_i.channel_sel);
  assign ram_raddr = AddrW'(key_q) * AddrW'(NumCh) + AddrW'(ch_q);

  skpi_ram #(.Width(32), .Depth(StoreDepth)) u_key_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_req_i.key_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // spline numerators scaled by 6*2^48
  always_comb begin
    logic signed [63:0] t1, t2, t3, tc;
    t1 = $signed(64'(u3_q));
    t2 = $signed(64'(u2_q)) <<< FracBits;
    t3 = $signed(64'(phase_q)) <<< (2 * FracBits);
    tc = 64'sd1 <<< (3 * FracBits);
    wn = '0;
    if (spline_mode_q) begin
      case (widx_q)
        2'd0:    wn = -t1 + 64'sd3 * t2 - 64'sd3 * t3 + tc;
        2'd1:    wn = 64'sd3 * t1 - 64'sd6 * t2 + 64'sd4 * tc;
        2'd2:    wn = -64'sd3 * t1 + 64'sd3 * t2 + 64'sd3 * t3 + tc;
        default: wn = t1;
      endcase
    end else begin
      case (widx_q)
        2'd0:    wn = 64'sd3 * (-t1 + 64'sd2 * t2 - t3);
        2'd1:    wn = 64'sd3 * (64'sd3 * t1 - 64'sd5 * t2 + 64'sd2 * tc);
        2'd2:    wn = 64'sd3 * (-64'sd3 * t1 + 64'sd4 * t2 + t3);
        default: wn = 64'sd3 * (t1 - t2);
      endcase
    end
    wn_num = ((wn[63] ? (64'd0 - wn) : wn) + (64'd3 << 20)) >> 20;
  end

  // shared multiplier operands
  always_comb begin
    unique case (mat_idx_q)
      4'd0:    begin opa = 3'd2; opb = 3'd2; end
      4'd1:    begin opa = 3'd3; opb = 3'd3; end
      4'd2:    begin opa = 3'd1; opb = 3'd2; end
      4'd3:    begin opa = 3'd0; opb = 3'd3; end
      4'd4:    begin opa = 3'd1; opb = 3'd3; end
      4'd5:    begin opa = 3'd0; opb = 3'd2; end
      4'd6:    begin opa = 3'd1; opb = 3'd1; end
      4'd7:    begin opa = 3'd2; opb = 3'd3; end
      default: begin opa = 3'd0; opb = 3'd1; end
    endcase
    case (state_q)
      ST_A_MUL: begin mul_a = w_q[widx_q]; mul_b = $signed(ram_rdata); end
      ST_N_MUL: begin mul_a = q_q[{1'b0, widx_q}]; mul_b = q_q[{1'b0, widx_q}]; end
      ST_M_MUL: begin mul_a = q_q[opa]; mul_b = q_q[opb]; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    div_sh    = {div_rem_q[32:0], div_num_q[63]};
    div_ge    = div_sh >= 34'(div_den_q);
    acc_new   = acc_q + prod_q;
    norm_wide = 65'(norm_q) + 65'(prod_q);
    norm_sum  = norm_wide[64] ? {64{1'b1}} : norm_wide[63:0];
    norm_diff = (norm_q > NormOne) ? norm_q - NormOne : NormOne - norm_q;
    renorm    = (norm_q != 64'd0) && (norm_diff > NormTol);
    sq_trial  = sq_res_q + sq_bit_q;
    quot_s    = div_neg_q ? -$signed(div_num_q) : $signed(div_num_q);
    nq_x      = q_q[{1'b0, widx_q}];
    nq_mag    = ((nq_x[31] ? (64'd0 - 64'(nq_x)) : 64'(nq_x)) << FracBits)
                + (sq_res_q >> 1);
    phase_sum = {1'b0, phase_q} + {1'b0, phase_step_q};
    res_d.rot_0_0 = one_minus(mat_q[0], mat_q[1]);
    res_d.rot_1_0 = twice_sum(mat_q[2], mat_q[3]);
    res_d.rot_2_0 = twice_sum(mat_q[4], -mat_q[5]);
    res_d.rot_0_1 = twice_sum(mat_q[2], -mat_q[3]);
    res_d.rot_1_1 = one_minus(mat_q[6], mat_q[1]);
    res_d.rot_2_1 = twice_sum(mat_q[7], mat_q[8]);
    res_d.rot_0_2 = twice_sum(mat_q[4], mat_q[5]);
    res_d.rot_1_2 = twice_sum(mat_q[7], -mat_q[8]);
    res_d.rot_2_2 = one_minus(mat_q[6], mat_q[0]);
    res_d.pos_x   = q_q[4];
    res_d.pos_y   = q_q[5];
    res_d.pos_z   = q_q[6];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc && is_tick) state_d = ST_U3;
      ST_U3:      state_d = ST_W_START;
      ST_W_START: state_d = ST_W_RUN;
      ST_W_RUN:   state_d = ST_W_DONE;
      ST_W_DONE:  state_d = (widx_q == 2'd3) ? ST_A_RD : ST_W_START;
      ST_A_RD:    state_d = ST_A_MUL;
      ST_A_MUL:   state_d = ST_A_ADD;
      ST_A_ADD: begin
        if (widx_q == 2'd3 && ch_q == 3'(NumCh - 1)) state_d = ST_N_MUL;
        else state_d = ST_A_RD;
      end
      ST_N_MUL:   state_d = ST_N_ADD;
      ST_N_ADD:   state_d = (widx_q == 2'd3) ? ST_N_CHK : ST_N_MUL;
      ST_N_CHK:   state_d = renorm ? ST_S_RUN : ST_M_MUL;
      ST_S_RUN:   if (sq_bit_q[0]) state_d = ST_N_START;
      ST_N_START: state_d = ST_N_RUN;
      ST_N_RUN:   if (div_cnt_q == 6'd63) state_d = ST_N_DONE;
      ST_N_DONE:  state_d = (widx_q == 2'd3) ? ST_M_MUL : ST_N_START;
      ST_M_MUL:   if (mat_idx_q == 4'd8) state_d = ST_FIN;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    ram_we      = in_acc && !is_tick && (in_req_i.channel_sel < 3'(NumCh));
    out_valid_o = out_valid_q;
    out_res_o   = out_res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_step_q  <= 16'd655;
      spline_mode_q <= 1'b1;
      key_count_q   <= 4'd5;
      phase_q       <= '0;
      segment_q     <= '0;
      out_valid_q   <= 1'b0;
      widx_q        <= '0;
      ch_q          <= '0;
      mat_idx_q     <= '0;
      div_cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i;
          CFG_SPLINE_MODE: spline_mode_q <= cfg_data_i[0];
          CFG_KEY_COUNT:   key_count_q   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          widx_q    <= '0;
          ch_q      <= '0;
          mat_idx_q <= '0;
        end
        ST_N_START: div_cnt_q <= '0;
        ST_N_RUN:   div_cnt_q <= div_cnt_q + 1'b1;
        ST_W_DONE, ST_N_ADD, ST_N_DONE: widx_q <= widx_q + 1'b1;
        ST_A_ADD: begin
          widx_q <= widx_q + 1'b1;
          if (widx_q == 2'd3) ch_q <= (ch_q == 3'(NumCh - 1)) ? 3'd0 : ch_q + 1'b1;
        end
        ST_M_MUL: mat_idx_q <= mat_idx_q + 1'b1;
        ST_FIN: begin
          if (out_free) begin
            if (phase_sum[16]) begin
              phase_q   <= '0;
              segment_q <= (({1'b0, segment_q} + (KeyW+1)'(1)) >= cnt_eff) ? '0
                           : segment_q + 1'b1;
            end else begin
              phase_q <= phase_sum[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_N_RUN) begin
      div_rem_q <= div_ge ? div_sh - 34'(div_den_q) : div_sh;
      div_num_q <= {div_num_q[62:0], div_ge};
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_tick) begin
          u2_q       <= 32'(phase_q) * 32'(phase_q);
          base_key_q <= seg_mod(segment_q, cnt_eff);
          acc_q      <= '0;
        end
      end
      ST_U3: u3_q <= 48'(u2_q) * 48'(phase_q);
      ST_W_START: begin
        div_num_q <= wn_num;
        div_neg_q <= wn[63];
      end
      // divide by 6 through the reciprocal, quotient in bits 63:34
      ST_W_RUN: div_num_q <= 64'(div_num_q[31:0]) * 64'(32'haaaaaaab);
      ST_W_DONE: begin
        w_q[widx_q] <= div_neg_q ? -$signed({2'b00, div_num_q[63:34]})
                                 : $signed({2'b00, div_num_q[63:34]});
        key_q       <= base_key_q;
      end
      ST_A_MUL: prod_q <= mul_p;
      ST_A_ADD: begin
        if (widx_q == 2'd3) begin
          q_q[ch_q] <= sat32(rnd_shr(acc_new, WgtBits));
          acc_q     <= '0;
          key_q     <= base_key_q;
          norm_q    <= '0;
        end else begin
          acc_q <= acc_new;
          key_q <= key_next;
        end
      end
      ST_N_MUL: prod_q <= mul_p;
      ST_N_ADD: norm_q <= norm_sum;
      ST_N_CHK: begin
        sq_rem_q <= norm_q;
        sq_res_q <= '0;
        sq_bit_q <= 64'd1 << 62;
      end
      ST_S_RUN: begin
        if (sq_rem_q >= sq_trial) begin
          sq_rem_q <= sq_rem_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      ST_N_START: begin
        div_num_q <= nq_mag;
        div_den_q <= sq_res_q[32:0];
        div_rem_q <= '0;
        div_neg_q <= nq_x[31];
      end
      ST_N_DONE: q_q[{1'b0, widx_q}] <= sat32(quot_s);
      ST_M_MUL:  mat_q[mat_idx_q] <= mul_p;
      ST_FIN:    if (out_free) out_res_q <= res_d;
      default: ;
    endcase
  end

  `SKPI_ASSERT_IMP(a_div_rem, state_q == ST_N_RUN, div_rem_q < 34'(div_den_q))
  `SKPI_ASSERT_IMP(a_sqrt_bit, state_q == ST_S_RUN, $onehot(sq_bit_q))
  `SKPI_ASSERT_IMP(a_key_range, state_q == ST_A_RD, (KeyW+1)'(key_q) < cnt_eff)
  `SKPI_ASSERT_NXT(a_fin_out, (state_q == ST_FIN) && out_free, out_valid_q && (state_q == ST_IDLE))

endmodule

@@ tb/spline_keyframe_pose_interpolator_chk.sv @@
// checker for the keyframe pose interpolator: watches request and result channels,
// predicts each tick result and compares it; depends on skpi_pkg
`timescale 1ns / 1ps

module spline_keyframe_pose_interpolator_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  skpi_pkg::skpi_req_t in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  skpi_pkg::skpi_res_t out_res_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  ticks_o,
  output int                  renorm_o
);
  import skpi_pkg::*;

  logic signed [31:0] keys [StoreDepth];
  logic [15:0] phase_q, step_q;
  logic [2:0]  seg_q;
  logic        mode_q;
  logic [3:0]  cnt_q;
  skpi_res_t   pose_q [$];

  function automatic logic signed [63:0] rdiv_away(input logic signed [63:0] x,
                                                   input logic [63:0] d);
    logic [63:0] mag;
    mag = x[63] ? (64'd0 - x) : x;
    mag = (mag + d / 2) / d;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] dbl_term(input logic signed [63:0] p1,
                                                  input logic signed [63:0] p2);
    return clip32(rdiv_away(add_sat(p1, p2), 64'd1 << 31));
  endfunction

  function automatic logic signed [31:0] diag_term(input logic signed [63:0] p1,
                                                   input logic signed [63:0] p2);
    return clip32(64'sd65536 - rdiv_away(add_sat(p1, p2), 64'd1 << 31));
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_pose();
    int unsigned cnt, idx;
    logic signed [63:0] u, u2, u3, acc, m, a, x, y, z;
    logic signed [63:0] n [4];
    logic signed [63:0] w [4];
    logic signed [63:0] q [7];
    logic [63:0] norm, sq, diff;
    skpi_res_t r;
    cnt = (cnt_q == 0) ? 1 : (cnt_q > MaxKeys ? MaxKeys : cnt_q);
    u = phase_q;
    u2 = u * u;
    u3 = u2 * u;
    if (mode_q) begin
      n[0] = -u3 + 3 * u2 * 65536 - 3 * u * 64'sd4294967296 + 64'sd281474976710656;
      n[1] = 3 * u3 - 6 * u2 * 65536 + 4 * 64'sd281474976710656;
      n[2] = -3 * u3 + 3 * u2 * 65536 + 3 * u * 64'sd4294967296 + 64'sd281474976710656;
      n[3] = u3;
    end else begin
      n[0] = 3 * (-u3 + 2 * u2 * 65536 - u * 64'sd4294967296);
      n[1] = 3 * (3 * u3 - 5 * u2 * 65536 + 2 * 64'sd281474976710656);
      n[2] = 3 * (-3 * u3 + 4 * u2 * 65536 + u * 64'sd4294967296);
      n[3] = 3 * (u3 - u2 * 65536);
    end
    for (int i = 0; i < 4; i++) w[i] = rdiv_away(n[i], 64'd6291456);
    for (int c = 0; c < NumCh; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        idx = ((seg_q + k) % cnt) * NumCh + c;
        acc += w[k] * 64'(keys[idx]);
      end
      q[c] = clip32(rdiv_away(acc, 64'd1 << WgtBits));
    end
    norm = 0;
    for (int i = 0; i < 4; i++) begin
      sq = q[i] * q[i];
      norm = (norm > ~64'd0 - sq) ? ~64'd0 : norm + sq;
    end
    diff = (norm > NormOne) ? norm - NormOne : NormOne - norm;
    if (norm != 0 && diff > NormTol) begin
      renorm_o++;
      m = int_sqrt(norm);
      for (int i = 0; i < 4; i++) q[i] = clip32(rdiv_away(q[i] <<< 16, m));
    end
    a = q[0]; x = q[1]; y = q[2]; z = q[3];
    r.rot_0_0 = diag_term(y * y, z * z);
    r.rot_1_0 = dbl_term(x * y, a * z);
    r.rot_2_0 = dbl_term(x * z, -(a * y));
    r.rot_0_1 = dbl_term(x * y, -(a * z));
    r.rot_1_1 = diag_term(x * x, z * z);
    r.rot_2_1 = dbl_term(y * z, a * x);
    r.rot_0_2 = dbl_term(x * z, a * y);
    r.rot_1_2 = dbl_term(y * z, -(a * x));
    r.rot_2_2 = diag_term(x * x, y * y);
    r.pos_x = q[4][31:0];
    r.pos_y = q[5][31:0];
    r.pos_z = q[6][31:0];
    pose_q.push_back(r);
    if (17'(phase_q) + 17'(step_q) >= 17'd65536) begin
      phase_q = 0;
      seg_q = (seg_q + 1 >= cnt) ? 3'd0 : seg_q + 3'd1;
    end else begin
      phase_q = phase_q + step_q;
    end
  endtask

  assign pending_o = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    skpi_res_t e;
    if (!rst_ni) begin
      phase_q = 0; seg_q = 0; step_q = 16'd655; mode_q = 1'b1; cnt_q = 4'd5;
      pose_q.delete();
      fail_cnt_o = 0; ticks_o = 0; renorm_o = 0;
      for (int i = 0; i < StoreDepth; i++) keys[i] = 0;
    end else begin
      if (cfg_we_i) begin
        case (skpi_cfg_e'(cfg_idx_i))
          CFG_PHASE_STEP:  step_q = cfg_data_i;
          CFG_SPLINE_MODE: mode_q = cfg_data_i[0];
          CFG_KEY_COUNT:   cnt_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("unexpected result %h", out_res_i);
        end else begin
          e = pose_q.pop_front();
          if (e !== out_res_i) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10) $display("mismatch exp %h got %h", e, out_res_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.req_type == REQ_TICK) begin
          ticks_o++;
          predict_pose();
        end else if (in_req_i.channel_sel < NumCh) begin
          keys[in_req_i.key_slot * NumCh + in_req_i.channel_sel] = in_req_i.key_value;
        end
      end
    end
  end
endmodule

@@ tb/spline_keyframe_pose_interpolator_tb.sv @@
// testbench top for the keyframe pose interpolator: clock, reset, config phases,
// load and tick stimulus; depends on skpi_pkg, the block and its checker
`timescale 1ns / 1ps

module spline_keyframe_pose_interpolator_tb;
  import skpi_pkg::*;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  skpi_req_t in_req_i;
  skpi_res_t out_res_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  int fail_cnt, pending, ticks, renorms;
  bit calm;

  spline_keyframe_pose_interpolator u_dut (.*);

  spline_keyframe_pose_interpolator_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_res_i(out_res_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .ticks_o(ticks), .renorm_o(renorms)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 6);

  // valid stays high after an accepted request until the next idle or request
  task automatic send(input skpi_req_t r);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_key(input int slot, input int ch, input logic [31:0] v);
    skpi_req_t r;
    r.req_type = REQ_LOAD;
    r.key_slot = 3'(slot);
    r.channel_sel = 3'(ch);
    r.key_value = v;
    send(r);
  endtask

  task automatic tick();
    skpi_req_t r;
    r.req_type = REQ_TICK;
    r.key_slot = 3'($urandom);
    r.channel_sel = 3'($urandom);
    r.key_value = $urandom;
    send(r);
  endtask

  task automatic write_cfg(input skpi_cfg_e idx, input logic [15:0] v);
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (700) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(65536 + 300, 65536 - 300);
      3: return $signed($urandom_range(40000)) - 20000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, guard;
    in_valid_i = 0; in_req_i = '0; cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    out_stall_i = 0; calm = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // fill every key, unit quaternion on most
    for (int s = 0; s < MaxKeys; s++)
      for (int c = 0; c < NumCh; c++)
        load_key(s, c, (c == 0) ? 32'h00010000 : 32'h0);
    load_key(1, 0, 32'h7fffffff);
    load_key(2, 1, 32'h80000000);
    load_key(3, 4, 32'h7fffffff);
    load_key(4, 6, 32'h80000000);
    load_key(0, 7, 32'h12345678);
    for (int i = 0; i < 4; i++) tick();
    write_cfg(CFG_KEY_COUNT, 16'd0);
    tick(); tick();
    write_cfg(CFG_KEY_COUNT, 16'd15);
    write_cfg(CFG_PHASE_STEP, 16'hffff);
    tick(); tick(); tick();
    write_cfg(CFG_SPLINE_MODE, 16'd0);
    write_cfg(CFG_PHASE_STEP, 16'd0);
    tick(); tick();
    n = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_PHASE_STEP, (ph == 0) ? 16'hffff : 16'($urandom_range(1, 30000)));
      write_cfg(CFG_SPLINE_MODE, 16'(ph[0]));
      write_cfg(CFG_KEY_COUNT, (ph == 1) ? 16'd1 : (ph == 2 ? 16'd8 : 16'($urandom)));
      calm = (ph == 4);
      repeat (190) begin
        if ($urandom_range(99) < 60) begin
          load_key($urandom, $urandom_range(99) < 95 ? $urandom_range(6) : 7, rand_val());
        end else begin
          tick();
        end
        n++;
      end
    end
    in_valid_i <= 1'b0;
    calm = 0;
    guard = 0;
    while (pending != 0 && guard < 2000000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (700) @(negedge clk_i);
    $display("%0d requests in the random phases, %0d ticks checked, %0d renormalized",
             n, ticks, renorms);
    $display("covered several step, basis and key count settings with random stalls");
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ spline_keyframe_pose_interpolator.f @@
+incdir+rtl
rtl/skpi_pkg.sv
rtl/skpi_ram.sv
rtl/spline_keyframe_pose_interpolator.sv
tb/spline_keyframe_pose_interpolator_chk.sv
tb/spline_keyframe_pose_interpolator_tb.sv
